>>> rtl/core/stable_priority_queue_top_macros.svh
// Assertion macros shared by the priority queue checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/spq_pkg.sv
// Types and constants of the sorted priority queue.
// No dependencies; used by the cell, the top level and the checker.
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int OCC_W = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] item_value;
    logic [2:0] item_priority;
  } in_item_t;

  typedef struct packed {
    logic             removed_valid;
    logic [7:0]       removed_value;
    logic [2:0]       removed_priority;
    status_t          status;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic [2:0] prio;
  } entry_t;

  // Strobes that move the whole chain together.
  typedef struct packed {
    logic ins;
    logic rem;
  } cmd_t;

endpackage

>>> rtl/core/spq_cell.sv
// One slot of the sorted chain: holds an entry and hands it to a neighbor.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic   clk,
  input  cmd_t   cmd,
  input  entry_t new_entry,
  input  entry_t prev_entry,
  input  entry_t next_entry,
  input  logic   prev_keep,
  input  logic   occupied,
  output logic   keep,
  output entry_t entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  // A held entry stays in place when it ranks at or above the new one.
  assign keep  = occupied && (entry_r.prio >= new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (cmd.ins) begin
      // The first cell that does not keep takes the new entry; the rest shift.
      if (!keep) begin
        entry_nxt = prev_keep ? new_entry : prev_entry;
      end
    end else if (cmd.rem) begin
      entry_nxt = next_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> rtl/core/stable_priority_queue_top.sv
// Top level of the sorted priority queue: a chain of slot cells, the fill
// count and the result register. Depends on spq_pkg and spq_cell.
//
// The queue accepts one insert or remove transaction per clock cycle and
// returns its result in the output register on the next cycle. Every slot
// compares its priority with the incoming one in parallel and the chain
// shifts by one position at once, so the rate is one transaction
// per cycle for as long as the result side does not stall; in_stall follows
// out_stall while a result is waiting. Entries of equal priority leave in
// arrival order. An insert into a full queue is dropped with status full,
// a remove from an empty queue reports status empty. No clearing pass is
// needed after reset.
module stable_priority_queue_top
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_item_t        out_data_r;
  out_item_t        out_data_nxt;

  logic             accept;
  logic             full;
  logic             empty;
  logic             is_ins;
  cmd_t             cmd;
  entry_t           new_entry;

  entry_t           entries [QUEUE_DEPTH];
  logic             keeps   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occupied;

  logic [CNT_W+OCC_W-1:0] occ_wide;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign is_ins    = (in_data.opcode == OP_INSERT);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign cmd.ins   = accept && is_ins && !full;
  assign cmd.rem   = accept && !is_ins && !empty;
  assign new_entry = '{value: in_data.item_value, prio: in_data.item_priority};

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_t prev_e;
      entry_t next_e;
      logic   prev_k;

      assign occupied[i] = (CNT_W'(i) < count_r);

      if (i == 0) begin : g_first
        assign prev_e = new_entry;
        assign prev_k = 1'b1;
      end else begin : g_mid
        assign prev_e = entries[i-1];
        assign prev_k = keeps[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
        assign next_e = entries[i];
      end else begin : g_inner
        assign next_e = entries[i+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .new_entry  (new_entry),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .prev_keep  (prev_k),
        .occupied   (occupied[i]),
        .keep       (keeps[i]),
        .entry      (entries[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign occ_wide = {{OCC_W{1'b0}}, count_nxt};

  always_comb begin
    out_data_nxt                  = '0;
    out_data_nxt.occupancy        = occ_wide[OCC_W-1:0];
    unique case (in_data.opcode)
      OP_INSERT: begin
        out_data_nxt.status = full ? ST_FULL : ST_OK;
      end
      OP_REMOVE: begin
        if (empty) begin
          out_data_nxt.status = ST_EMPTY;
        end else begin
          out_data_nxt.status           = ST_OK;
          out_data_nxt.removed_valid    = 1'b1;
          out_data_nxt.removed_value    = entries[0].value;
          out_data_nxt.removed_priority = entries[0].prio;
        end
      end
      default: begin
        out_data_nxt.status = ST_OK;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/spq_checker.sv
// Port-level checks of the priority queue and their bind to the top level.
// Depends on spq_pkg and stable_priority_queue_top_macros.svh.
`include "stable_priority_queue_top_macros.svh"

module spq_checker
  import spq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic empty_seen;
  logic empty_clean;

  assign empty_seen  = out_valid && (out_data.status == ST_EMPTY);
  assign empty_clean = !out_data.removed_valid && (out_data.occupancy == '0);

  // Every accepted transaction leaves a result in the output register.
  `SPQ_ASSERT_NXT(a_result_follows, in_valid && !in_stall, out_valid, "no result after accept")

  // The input side only stalls while a result waits on a stalled output.
  `SPQ_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "stall without cause")

  // A waiting result stays valid and holds its payload.
  `SPQ_ASSERT_NXT(a_valid_hold, out_valid && out_stall, out_valid, "stalled result dropped")
  `SPQ_ASSERT_NXT(a_out_hold, out_valid && out_stall, $stable(out_data), "result changed")

  // An empty report carries no entry and a zero occupancy.
  `SPQ_ASSERT_IMP(a_empty_result, empty_seen, empty_clean, "bad empty result")

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (.*);

>>> verif/tb_stable_priority_queue_top.sv
// Testbench for stable_priority_queue_top: directed and random insert/remove traffic,
// each result checked against a sorted-queue predictor kept in the bench.
// Depends on spq_pkg and the RTL of the block.
module tb_stable_priority_queue_top;
  import spq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOWN_MISMATCHES = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Predicted queue contents in service order.
  logic [7:0] held_value [DEPTH];
  logic [2:0] held_prio [DEPTH];
  int         held_count = 0;

  out_item_t  pending_results [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  bit         burst_mode = 1'b0;

  bit         result_taken = 1'b0;
  out_item_t  result_seen;
  int         stall_left = 0;

  stable_priority_queue_top #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic op, logic [7:0] value, logic [2:0] prio);
    in_item_t it;
    it.opcode = op;
    it.item_value = value;
    it.item_priority = prio;
    return it;
  endfunction

  // Applies one transaction to the predicted queue and returns the result it causes.
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    int pos;
    int i;
    r = '0;
    r.status = ST_OK;
    if (it.opcode == OP_INSERT) begin
      if (held_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // The new entry goes behind every entry of greater or equal priority.
        pos = 0;
        while (pos < held_count && held_prio[pos] >= it.item_priority) pos++;
        for (i = held_count; i > pos; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_value[pos] = it.item_value;
        held_prio[pos] = it.item_priority;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.removed_valid = 1'b1;
      r.removed_value = held_value[0];
      r.removed_priority = held_prio[0];
      for (i = 1; i < held_count; i++) begin
        held_value[i-1] = held_value[i];
        held_prio[i-1] = held_prio[i];
      end
      held_count--;
    end
    r.occupancy = OCC_W'(held_count);
    return r;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    bit taken;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    // Stall is sampled at the falling edge ahead of the edge that would take the transaction.
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    pending_results.push_back(predict_result(it));
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= SHOWN_MISMATCHES)
        $display("ERROR: result with no transaction outstanding: %p", got);
      return;
    end
    want = pending_results.pop_front();
    if (got.removed_valid !== want.removed_valid ||
        got.removed_value !== want.removed_value ||
        got.removed_priority !== want.removed_priority ||
        got.status !== want.status ||
        got.occupancy !== want.occupancy) begin
      mismatch_count++;
      if (mismatch_count <= SHOWN_MISMATCHES)
        $display("ERROR: expected valid=%0d value=%0d prio=%0d status=%0d occ=%0d, got valid=%0d value=%0d prio=%0d status=%0d occ=%0d",
                 want.removed_valid, want.removed_value, want.removed_priority, want.status,
                 want.occupancy, got.removed_valid, got.removed_value, got.removed_priority,
                 got.status, got.occupancy);
    end
  endtask

  always @(negedge clk) begin
    result_taken = rst_n && out_valid && !out_stall;
    result_seen = out_data;
  end

  // Result side: after each result it takes, it holds off for a random number of cycles, except in burst mode.
  always @(posedge clk) begin
    if (result_taken) begin
      check_result(result_seen);
      stall_left = burst_mode ? 0 : $urandom_range(0, 15);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  task automatic test_remove_empty();
    send_item(make_item(OP_REMOVE, 8'hFF, 3'd7));
    send_item(make_item(OP_REMOVE, 8'h00, 3'd0));
  endtask

  // Sixteen inserts with repeated priorities fill the queue; two more are dropped.
  task automatic test_fill_to_full();
    logic [2:0] prio_seq [16] = '{3'd0, 3'd7, 3'd3, 3'd3, 3'd7, 3'd0, 3'd5, 3'd3,
                                  3'd1, 3'd7, 3'd2, 3'd6, 3'd4, 3'd3, 3'd0, 3'd5};
    for (int i = 0; i < DEPTH; i++)
      send_item(make_item(OP_INSERT, 8'(i * 17), prio_seq[i % 16]));
    send_item(make_item(OP_INSERT, 8'hFF, 3'd7));
    send_item(make_item(OP_INSERT, 8'h00, 3'd0));
  endtask

  task automatic test_drain_order();
    for (int i = 0; i < 5; i++)
      send_item(make_item(OP_REMOVE, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7))));
  endtask

  // Blocks of traffic lean toward inserts, removes or neither so the queue runs both
  // full and empty; some use at most two priorities to stress ordering among equals.
  task automatic test_random_traffic();
    int insert_pct;
    bit narrow;
    logic [2:0] prio_a;
    logic [2:0] prio_b;
    logic [2:0] prio;
    logic op;
    for (int blk = 0; blk < 20; blk++) begin
      case ($urandom_range(0, 2))
        0: insert_pct = 20;
        1: insert_pct = 50;
        default: insert_pct = 80;
      endcase
      narrow = ($urandom_range(0, 1) == 1);
      prio_a = 3'($urandom_range(0, 7));
      prio_b = 3'($urandom_range(0, 7));
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 50; k++) begin
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        if (narrow)
          prio = $urandom_range(0, 1) ? prio_a : prio_b;
        else
          prio = 3'($urandom_range(0, 7));
        send_item(make_item(op, 8'($urandom_range(0, 255)), prio));
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_remove_empty();
    test_fill_to_full();
    test_drain_order();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
